>>> src/first_fit_block_allocator_top_defines.svh
// ============================================================================
// Assertion macros for the first-fit block allocator
// Shared concurrent assertion forms, clocked and disabled during reset.
// ============================================================================
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_TOP_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define FFBA_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("allocator assertion failed");

// Next-cycle implication, disabled while reset is high.
`define FFBA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("allocator assertion failed");

`endif

>>> src/ffba_pkg.sv
// ============================================================================
// ffba_pkg
// Types and constants shared by the first-fit block allocator files.
// ============================================================================
`timescale 1ns / 1ps

package ffba_pkg;

  localparam int DEF_HEAP_BYTES   = 65536;
  localparam int DEF_HEADER_BYTES = 24;
  localparam int DEF_MAX_BLOCKS   = 64;

  localparam int ADDR_W     = 16;
  localparam int SIZE_W     = 16;
  localparam int HEAP_TOP_W = 17;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ZERO    = 2'd1;
  localparam logic [1:0] ST_NOSPACE = 2'd2;
  localparam logic [1:0] ST_UNKNOWN = 2'd3;

  typedef struct packed {
    logic              func;
    logic [SIZE_W-1:0] request_size;
    logic [ADDR_W-1:0] data_address;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] result_address;
  } rsp_t;

  // One block table entry as stored in the table memory.
  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [SIZE_W-1:0] size;
    logic              free;
  } blk_t;

endpackage

>>> src/ffba_ram.sv
// ============================================================================
// ffba_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ============================================================================
`timescale 1ns / 1ps

module ffba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/first_fit_block_allocator_top.sv
// ============================================================================
// first_fit_block_allocator_top
// First-fit heap allocator that keeps its block table in one memory.
// ============================================================================
//
//   Channel | Direction | Handshake           | Payload
//   --------+-----------+---------------------+---------------------------
//   req     | in        | req_valid/req_stall | req_t  (func, size, addr)
//   rsp     | out       | rsp_valid/rsp_stall | rsp_t  (status, address)
//
// One transaction is worked at a time. An allocate or free reads the table one entry
// per cycle in creation order, over the blocks created so far, and a hit stops the
// scan early. Zero size and null free skip the scan. Reset clears the block count,
// the heap top, the state and the valid flags, not the table memory. A stalled
// response holds the next request in S_OUT until the response register is free.
`timescale 1ns / 1ps
`include "first_fit_block_allocator_top_defines.svh"

module first_fit_block_allocator_top
  import ffba_pkg::*;
#(
  parameter int HEAP_BYTES   = DEF_HEAP_BYTES,
  parameter int HEADER_BYTES = DEF_HEADER_BYTES,
  parameter int MAX_BLOCKS   = DEF_MAX_BLOCKS
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int NT_W  = HEAP_TOP_W + 1;
  localparam int DA_W  = ADDR_W + 1;

  // Sequencer: wait for a request, walk the table, hand over the response.
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_OUT  = 3'b100
  } state_t;

  state_t              state, state_next;
  req_t                cur, cur_next;
  logic [CNT_W-1:0]    idx, idx_next;
  logic                rd_valid, rd_valid_next;
  logic [IDX_W-1:0]    rd_idx, rd_idx_next;
  logic [CNT_W-1:0]    block_count, block_count_next;
  logic [HEAP_TOP_W-1:0] heap_top, heap_top_next;
  rsp_t                res, res_next;
  logic                rsp_valid_next;
  rsp_t                rsp_next;

  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  blk_t                ram_wdata;
  logic                ram_re;
  logic [IDX_W-1:0]    ram_raddr;
  blk_t                ram_rdata;

  logic                req_accept;
  logic                hit;
  logic                more;
  logic [NT_W-1:0]     need_top;
  logic [DA_W-1:0]     entry_data;

  ffba_ram #(
    .WIDTH ($bits(blk_t)),
    .DEPTH (MAX_BLOCKS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign req_stall  = (state != S_IDLE);
  assign req_accept = req_valid && !req_stall;

  // The entry read last cycle: its data address as a 17-bit sum, so that an
  // address past the 16-bit range never matches a request.
  assign entry_data = {1'b0, ram_rdata.base} + DA_W'(HEADER_BYTES);

  always_comb begin
    if (cur.func == FUNC_ALLOC) begin
      hit = rd_valid && ram_rdata.free && (ram_rdata.size >= cur.request_size);
    end else begin
      hit = rd_valid && (entry_data == {1'b0, cur.data_address});
    end
  end

  // Entries still to be read.
  assign more = (idx < block_count);

  // Heap end after appending a block of the requested size.
  assign need_top = {1'b0, heap_top} + NT_W'(HEADER_BYTES) + NT_W'(cur.request_size);

  always_comb begin
    state_next       = state;
    cur_next         = cur;
    idx_next         = idx;
    rd_valid_next    = 1'b0;
    rd_idx_next      = rd_idx;
    block_count_next = block_count;
    heap_top_next    = heap_top;
    res_next         = res;
    rsp_valid_next   = rsp_valid;
    rsp_next         = rsp;
    ram_we           = 1'b0;
    ram_waddr        = rd_idx;
    ram_wdata        = ram_rdata;
    ram_re           = 1'b0;
    ram_raddr        = idx[IDX_W-1:0];

    if (rsp_valid && !rsp_stall) begin
      rsp_valid_next = 1'b0;
    end

    unique case (state)
      S_IDLE: begin
        if (req_accept) begin
          cur_next = req;
          idx_next = '0;
          if ((req.func == FUNC_ALLOC && req.request_size == '0) ||
              (req.func == FUNC_FREE && req.data_address == '0)) begin
            res_next.status         = ST_ZERO;
            res_next.result_address = '0;
            state_next              = S_OUT;
          end else begin
            state_next = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (hit) begin
          // Update the matching entry in place; base and size are kept.
          ram_we    = 1'b1;
          ram_waddr = rd_idx;
          ram_wdata = ram_rdata;
          res_next.status = ST_OK;
          if (cur.func == FUNC_ALLOC) begin
            ram_wdata.free          = 1'b0;
            res_next.result_address = entry_data[ADDR_W-1:0];
          end else begin
            ram_wdata.free          = 1'b1;
            res_next.result_address = '0;
          end
          state_next = S_OUT;
        end else if (more) begin
          // Read the next entry; its data is checked in the following cycle.
          ram_re        = 1'b1;
          ram_raddr     = idx[IDX_W-1:0];
          rd_valid_next = 1'b1;
          rd_idx_next   = idx[IDX_W-1:0];
          idx_next      = idx + CNT_W'(1);
        end else begin
          // Every created block was checked without a match.
          res_next.result_address = '0;
          if (cur.func == FUNC_FREE) begin
            res_next.status = ST_UNKNOWN;
          end else if (block_count == CNT_W'(MAX_BLOCKS) ||
                       need_top > NT_W'(HEAP_BYTES)) begin
            res_next.status = ST_NOSPACE;
          end else begin
            ram_we                  = 1'b1;
            ram_waddr               = block_count[IDX_W-1:0];
            ram_wdata.base          = heap_top[ADDR_W-1:0];
            ram_wdata.size          = cur.request_size;
            ram_wdata.free          = 1'b0;
            block_count_next        = block_count + CNT_W'(1);
            heap_top_next           = need_top[HEAP_TOP_W-1:0];
            res_next.status         = ST_OK;
            res_next.result_address = heap_top[ADDR_W-1:0] + ADDR_W'(HEADER_BYTES);
          end
          state_next = S_OUT;
        end
      end

      S_OUT: begin
        // Load the response register once the previous response has left.
        if (!rsp_valid || !rsp_stall) begin
          rsp_valid_next = 1'b1;
          rsp_next       = res;
          state_next     = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      rd_valid    <= 1'b0;
      block_count <= '0;
      heap_top    <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      rd_valid    <= rd_valid_next;
      block_count <= block_count_next;
      heap_top    <= heap_top_next;
      rsp_valid   <= rsp_valid_next;
    end
    cur    <= cur_next;
    idx    <= idx_next;
    rd_idx <= rd_idx_next;
    res    <= res_next;
    rsp    <= rsp_next;
  end

  // A non-OK response never carries an address (an OK free response also returns zero).
  `FFBA_ASSERT_NOW(a_addr_zero_on_fail, clk, rst,
                   rsp_valid && rsp.status != ST_OK, rsp.result_address == '0)
  // The table never holds more blocks than it has entries.
  `FFBA_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, block_count <= CNT_W'(MAX_BLOCKS))
  // The heap top never runs past the end of the heap.
  `FFBA_ASSERT_NOW(a_heap_bound, clk, rst, 1'b1, heap_top <= HEAP_TOP_W'(HEAP_BYTES))
  // Each table write closes the scan and is followed by the response.
  `FFBA_ASSERT_NEXT(a_write_then_out, clk, rst, ram_we, state == S_OUT)
  // A block is appended only when the scan found no match.
  `FFBA_ASSERT_NOW(a_append_on_miss, clk, rst,
                   block_count_next != block_count, ram_we && !hit)

endmodule
